// File: rtl/core/vpqs_pkg.sv
// Shared constants, codes and handshake structs for the voice prompt queue sender.
`timescale 1ns / 1ps

package vpqs_pkg;

   localparam int CODE_W      = 8;
   localparam int FUNC_W      = 2;
   localparam int QUEUED_W    = 5;
   localparam int CSR_IDX_W   = 1;

   localparam int QUEUE_DEPTH = 16;
   localparam int START_TICKS = 12;

   // Start pulse, one high tick, then eight bits of four ticks each.
   localparam int FRAME_TICKS = START_TICKS + 1 + 4 * CODE_W;
   localparam int SLOT_W      = $clog2(FRAME_TICKS);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_TICK    = 2'd0,
      FUNC_APPEND  = 2'd1,
      FUNC_REPLACE = 2'd2,
      FUNC_POLL    = 2'd3
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STOP_CODE  = 1'd0,
      CSR_ALARM_CODE = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic              append;
      logic              replace;
      logic              pop;
      logic [CODE_W-1:0] code;
   } queue_cmd_type;

   typedef struct packed {
      logic                full;
      logic                has_code;
      logic [CODE_W-1:0]   head;
      logic [QUEUED_W-1:0] queued_next;
   } queue_status_type;

   typedef struct packed {
      logic              tick;
      logic              replace;
      logic              start;
      logic [CODE_W-1:0] code;
   } frame_cmd_type;

   typedef struct packed {
      logic active;
      logic stop_pending;
      logic active_next;
      logic line_next;
      logic started;
   } frame_status_type;

endpackage

// File: rtl/core/vpqs_queue.sv
// Prompt code queue: code store, fill count and play pointer.
`timescale 1ns / 1ps

module vpqs_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  vpqs_pkg::queue_cmd_type    cmd,
   output vpqs_pkg::queue_status_type status
);
   import vpqs_pkg::*;

   logic [CODE_W-1:0] store_ff [QUEUE_DEPTH];
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  ptr_ff, ptr_in;
   logic [CNT_W-1:0]  ptr_inc;
   logic              full;
   logic              do_append;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign do_append = cmd.append && !full;
   assign ptr_inc   = CNT_W'(ptr_ff) + CNT_W'(1);

   always_comb begin
      count_in = count_ff;
      ptr_in   = ptr_ff;
      if (cmd.replace) begin
         count_in = CNT_W'(1);
         ptr_in   = '0;
      end else if (do_append) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.pop) begin
         // Taking the last code empties the queue back to the start.
         if (ptr_inc >= count_ff) begin
            count_in = '0;
            ptr_in   = '0;
         end else begin
            ptr_in = ptr_inc[IDX_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ptr_ff   <= '0;
      end else begin
         count_ff <= count_in;
         ptr_ff   <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.replace) begin
         store_ff[0] <= cmd.code;
      end else if (do_append) begin
         store_ff[count_ff[IDX_W-1:0]] <= cmd.code;
      end
   end

   assign status.full        = full;
   assign status.has_code    = (CNT_W'(ptr_ff) < count_ff);
   assign status.head        = store_ff[ptr_ff];
   assign status.queued_next = QUEUED_W'(count_in - CNT_W'(ptr_in));

endmodule

// File: rtl/core/vpqs_frame.sv
// Frame timer: slot counter, line level, code being sent and deferred stop.
`timescale 1ns / 1ps

module vpqs_frame (
   input  logic                              clock,
   input  logic                              reset,
   input  vpqs_pkg::frame_cmd_type           cmd,
   input  logic [vpqs_pkg::CODE_W-1:0]       stop_code,
   output vpqs_pkg::frame_status_type        status
);
   import vpqs_pkg::*;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(FRAME_TICKS - 1);

   logic              active_ff, active_in;
   logic              pend_ff, pend_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [CODE_W-1:0] byte_ff, byte_in;
   logic              line_ff, line_in;
   logic              started;
   logic [SLOT_W-1:0] slot_inc;

   // Line level for a slot: start pulse low, one high tick, then the bits.
   function automatic logic level_of_slot(input logic [SLOT_W-1:0] slot,
                                          input logic [CODE_W-1:0] code);
      logic [SLOT_W-1:0] k;
      logic [2:0]        bitpos;
      logic [1:0]        phase;
      logic              one;
      k      = slot - SLOT_W'(START_TICKS + 1);
      bitpos = k[4:2];
      phase  = k[1:0];
      one    = code[3'd7 - bitpos];
      if (slot < SLOT_W'(START_TICKS)) begin
         level_of_slot = 1'b0;
      end else if (slot == SLOT_W'(START_TICKS)) begin
         level_of_slot = 1'b1;
      end else if (one) begin
         level_of_slot = (phase != 2'd0);
      end else begin
         level_of_slot = (phase == 2'd3);
      end
   endfunction

   assign slot_inc = slot_ff + SLOT_W'(1);

   always_comb begin
      active_in = active_ff;
      pend_in   = pend_ff;
      slot_in   = slot_ff;
      byte_in   = byte_ff;
      line_in   = line_ff;
      started   = 1'b0;

      if (cmd.tick && active_ff) begin
         if (slot_ff == LAST_SLOT) begin
            active_in = 1'b0;
            slot_in   = '0;
            line_in   = 1'b1;
            if (pend_ff) begin
               pend_in   = 1'b0;
               byte_in   = stop_code;
               active_in = 1'b1;
               line_in   = level_of_slot('0, stop_code);
               started   = 1'b1;
            end
         end else begin
            slot_in = slot_inc;
            line_in = level_of_slot(slot_inc, byte_ff);
         end
      end

      if (cmd.replace) begin
         if (active_ff) begin
            pend_in = 1'b1;
         end else begin
            byte_in   = stop_code;
            active_in = 1'b1;
            slot_in   = '0;
            line_in   = level_of_slot('0, stop_code);
            started   = 1'b1;
         end
      end

      if (cmd.start) begin
         byte_in   = cmd.code;
         active_in = 1'b1;
         slot_in   = '0;
         line_in   = level_of_slot('0, cmd.code);
         started   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pend_ff   <= 1'b0;
         slot_ff   <= '0;
         byte_ff   <= '0;
         line_ff   <= 1'b1;
      end else begin
         active_ff <= active_in;
         pend_ff   <= pend_in;
         slot_ff   <= slot_in;
         byte_ff   <= byte_in;
         line_ff   <= line_in;
      end
   end

   assign status.active       = active_ff;
   assign status.stop_pending = pend_ff;
   assign status.active_next  = active_in;
   assign status.line_next    = line_in;
   assign status.started      = started;

endmodule

// File: rtl/core/voice_prompt_queue_sender.sv
// Top level of the voice prompt queue sender: input register, control and result register.
`timescale 1ns / 1ps

//  Channel  | Direction | Handshake              | Payload
//  ---------+-----------+------------------------+-----------------------------------------
//  req_     | in        | req_valid / req_ready  | func, voice, busy_first, busy_second,
//           |           |                        | tamper
//  rsp_     | out       | rsp_valid / rsp_ready  | data_line, sending, queued, dropped,
//           |           |                        | frame_started
//  csr_     | in        | csr_valid / csr_ready  | index (0 stop code, 1 alarm code), wdata
//
// Each transfer on req_ is held in an input register and processed by the queue and
// frame update, producing exactly one transfer on rsp_ from the result register.
// One item per cycle is sustained while rsp_ready stays high; the queue and frame update
// lies between the two registers. Reset is synchronous and active high: the queue is
// emptied and the frame timer idles with its line level high. Stalls on rsp_
// hold the result register and the input register; req_ready drops only when both are full.
// Configuration writes are always taken and are written straight into the code registers.

module voice_prompt_queue_sender (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [vpqs_pkg::FUNC_W-1:0]       req_func,
   input  logic [vpqs_pkg::CODE_W-1:0]       req_voice,
   input  logic                              req_busy_first,
   input  logic                              req_busy_second,
   input  logic                              req_tamper,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_data_line,
   output logic                              rsp_sending,
   output logic [vpqs_pkg::QUEUED_W-1:0]     rsp_queued,
   output logic                              rsp_dropped,
   output logic                              rsp_frame_started,

   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [vpqs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [vpqs_pkg::CODE_W-1:0]       csr_wdata
);
   import vpqs_pkg::*;

   // Input register.
   logic              in_valid_ff;
   func_type          func_ff;
   logic [CODE_W-1:0] voice_ff;
   logic              busy1_ff;
   logic              busy2_ff;
   logic              tamper_ff;

   // Configuration registers.
   logic [CODE_W-1:0] stop_code_ff;
   logic [CODE_W-1:0] alarm_code_ff;

   // Result register.
   logic                rsp_valid_ff;
   logic                line_ff;
   logic                sending_ff;
   logic [QUEUED_W-1:0] queued_ff;
   logic                dropped_ff;
   logic                started_ff;

   logic              fire;
   logic              req_take;
   logic              poll_go;
   logic              dropped;

   queue_cmd_type     q_cmd;
   queue_status_type  q_status;
   frame_cmd_type     f_cmd;
   frame_status_type  f_status;

   // An item is processed when the result register is free or is being emptied.
   assign fire      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         func_ff   <= func_type'(req_func);
         voice_ff  <= req_voice;
         busy1_ff  <= req_busy_first;
         busy2_ff  <= req_busy_second;
         tamper_ff <= req_tamper;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_code_ff  <= '0;
         alarm_code_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_STOP_CODE:  stop_code_ff  <= csr_wdata;
            CSR_ALARM_CODE: alarm_code_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // A poll only acts when no frame is running or waiting and both busy samples
   // report the chip idle.
   assign poll_go = !f_status.active && !f_status.stop_pending && busy1_ff && busy2_ff;

   always_comb begin
      q_cmd   = '0;
      f_cmd   = '0;
      dropped = 1'b0;
      if (fire) begin
         case (func_ff)
            FUNC_TICK: begin
               f_cmd.tick = 1'b1;
            end
            FUNC_APPEND: begin
               q_cmd.append = 1'b1;
               q_cmd.code   = voice_ff;
               dropped      = q_status.full;
            end
            FUNC_REPLACE: begin
               q_cmd.replace = 1'b1;
               q_cmd.code    = voice_ff;
               f_cmd.replace = 1'b1;
            end
            FUNC_POLL: begin
               if (poll_go) begin
                  if (q_status.has_code) begin
                     // A zero code is consumed without sending a frame.
                     q_cmd.pop   = 1'b1;
                     f_cmd.start = (q_status.head != '0);
                     f_cmd.code  = q_status.head;
                  end else if (tamper_ff) begin
                     q_cmd.append = 1'b1;
                     q_cmd.code   = alarm_code_ff;
                     dropped      = q_status.full;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   vpqs_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .cmd    (q_cmd),
      .status (q_status)
   );

   vpqs_frame u_frame (
      .clock     (clock),
      .reset     (reset),
      .cmd       (f_cmd),
      .stop_code (stop_code_ff),
      .status    (f_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         line_ff    <= f_status.line_next;
         sending_ff <= f_status.active_next;
         queued_ff  <= q_status.queued_next;
         dropped_ff <= dropped;
         started_ff <= f_status.started;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data_line     = line_ff;
   assign rsp_sending       = sending_ff;
   assign rsp_queued        = queued_ff;
   assign rsp_dropped       = dropped_ff;
   assign rsp_frame_started = started_ff;

`ifndef SYNTHESIS
   // A deferred stop only exists behind a running frame.
   assert property (@(posedge clock) disable iff (reset)
      f_status.stop_pending |-> f_status.active)
      else $error("stop pending while no frame is active");

   // A full queue always has codes left to play.
   assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> q_status.has_code)
      else $error("queue full but play pointer has caught up");

   // A new frame opens with the line low and the sender busy.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_started) |-> (rsp_sending && !rsp_data_line))
      else $error("frame start reported without a low line");

   // A refused append cannot also start a frame.
   assert property (@(posedge clock) disable iff (reset)
      fire |=> !(rsp_dropped && rsp_frame_started))
      else $error("dropped and frame start reported together");
`endif

endmodule
